// File: sv/stepper_s_curve_profile_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepper S-curve profile generator
// Clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_S_CURVE_PROFILE_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_S_CURVE_PROFILE_GENERATOR_UNIT_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define SPCG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define SPCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/spcg_pkg.sv
// ----------------------------------------------------------------------------
// spcg_pkg
// Types, constants and helpers shared by the S-curve profile generator.
// ----------------------------------------------------------------------------
package spcg_pkg;

	localparam int TableDepthDefault  = 1024;
	localparam int PeriodWidthDefault = 16;

	localparam int IndexWidth = 10;
	localparam int TickWidth  = 11;
	localparam int StepWidth  = 16;
	localparam int LenWidth   = 17;
	localparam int OutWidth   = 16;
	localparam int CfgWidth   = 17;

	localparam logic [LenWidth-1:0]   MoveLengthReset = 17'd3200;
	localparam logic [StepWidth-1:0]  RampReset       = 16'd800;
	localparam logic [IndexWidth-1:0] TableLastReset  = 10'd799;
	localparam int                    PeriodReset     = 2000;

	typedef enum logic [1:0] {
		OP_TABLE_WRITE = 2'd0,
		OP_START       = 2'd1,
		OP_TICK        = 2'd2,
		OP_PULSE       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_MOVE_LENGTH   = 2'd0,
		CFG_ACCEL_REQUEST = 2'd1,
		CFG_DECEL_REQUEST = 2'd2,
		CFG_TABLE_LAST    = 2'd3
	} cfg_idx_t;

	// Per-item status carried from the control stage to the output stage.
	typedef struct packed {
		logic                 load;
		logic                 moving;
		logic                 done;
		logic [StepWidth-1:0] steps;
	} s1_t;

	// Reduces a table index modulo a depth that is not a power of two by
	// conditional subtraction of shifted copies of the depth.
	function automatic logic [IndexWidth-1:0] wrap_index(
		input logic [IndexWidth-1:0] idx,
		input int                    depth
	);
		logic [IndexWidth:0] r;
		int                  dk;
		r = {1'b0, idx};
		for (int k = IndexWidth - 1; k >= 0; k--) begin
			dk = depth << k;
			if (dk < (1 << IndexWidth) && r >= (IndexWidth + 1)'(dk)) begin
				r = r - (IndexWidth + 1)'(dk);
			end
		end
		return r[IndexWidth-1:0];
	endfunction

endpackage

// File: sv/spcg_table.sv
// ----------------------------------------------------------------------------
// spcg_table
// Profile table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spcg_table #(
	parameter int TABLE_DEPTH  = 1024,
	parameter int PERIOD_WIDTH = 16,
	parameter int AW           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [PERIOD_WIDTH-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic [PERIOD_WIDTH-1:0] rdata
);

	logic [PERIOD_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [PERIOD_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/spcg_ctrl.sv
// ----------------------------------------------------------------------------
// spcg_ctrl
// Configuration registers, move state and table addressing for each item.
// ----------------------------------------------------------------------------
module spcg_ctrl
	import spcg_pkg::*;
#(
	parameter int TABLE_DEPTH  = 1024,
	parameter int PERIOD_WIDTH = 16,
	parameter int AW           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CfgWidth-1:0]     cfg_data,
	input  logic                    accept,
	input  logic                    advance,
	input  logic [1:0]              op,
	input  logic [IndexWidth-1:0]   table_index,
	input  logic [15:0]             table_value,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output logic [PERIOD_WIDTH-1:0] mem_wdata,
	output logic                    mem_re,
	output logic [AW-1:0]           mem_raddr,
	output logic                    s1_valid,
	output s1_t                     s1
);

	localparam bit DirectIndex =
		(TABLE_DEPTH >= (1 << IndexWidth)) || ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

	logic [LenWidth-1:0]   move_length_q;
	logic [StepWidth-1:0]  accel_request_q;
	logic [StepWidth-1:0]  decel_request_q;
	logic [IndexWidth-1:0] table_last_q;

	logic [StepWidth-1:0]  step_q,    step_n;
	logic [TickWidth-1:0]  tick_q,    tick_n;
	logic                  running_q, running_n;
	logic [StepWidth-1:0]  accel_q,   accel_n;
	logic [StepWidth-1:0]  decel_q,   decel_n;

	logic                  s1_valid_q;
	s1_t                   s1_q;

	logic                  load;
	logic                  done;
	logic [IndexWidth-1:0] rd_idx;
	logic [LenWidth-1:0]   ramp_sum;
	logic [LenWidth-1:0]   step_next;
	logic signed [LenWidth:0] decel_start;
	logic signed [LenWidth:0] remain;
	op_t                   op_e;

	assign op_e = op_t'(op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_length_q   <= MoveLengthReset;
			accel_request_q <= RampReset;
			decel_request_q <= RampReset;
			table_last_q    <= TableLastReset;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MOVE_LENGTH:   move_length_q   <= cfg_data;
				CFG_ACCEL_REQUEST: accel_request_q <= cfg_data[StepWidth-1:0];
				CFG_DECEL_REQUEST: decel_request_q <= cfg_data[StepWidth-1:0];
				CFG_TABLE_LAST:    table_last_q    <= cfg_data[IndexWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		step_n      = step_q;
		tick_n      = tick_q;
		running_n   = running_q;
		accel_n     = accel_q;
		decel_n     = decel_q;
		load        = 1'b0;
		done        = 1'b0;
		rd_idx      = '0;
		mem_we      = 1'b0;
		ramp_sum    = {1'b0, accel_request_q} + {1'b0, decel_request_q};
		step_next   = {1'b0, step_q} + 17'd1;
		decel_start = $signed({1'b0, move_length_q}) - $signed({2'b00, decel_q});
		remain      = $signed({1'b0, move_length_q}) - $signed({2'b00, step_q});
		unique case (op_e)
			OP_TABLE_WRITE: begin
				mem_we = 1'b1;
			end
			OP_START: begin
				// A move too short for both ramps splits it evenly between them.
				if (move_length_q < ramp_sum) begin
					accel_n = move_length_q[LenWidth-1:1];
					decel_n = move_length_q[LenWidth-1:1];
				end else begin
					accel_n = accel_request_q;
					decel_n = decel_request_q;
				end
				step_n    = '0;
				tick_n    = '0;
				running_n = 1'b1;
				load      = 1'b1;
			end
			OP_TICK: begin
				if (running_q) begin
					if (step_q <= accel_q) begin
						if (tick_q <= {1'b0, table_last_q}) begin
							load   = 1'b1;
							rd_idx = tick_q[IndexWidth-1:0];
							tick_n = tick_q + 11'd1;
						end
					end else if ($signed({2'b00, step_q}) > decel_start) begin
						// Walk back down the table by the steps that remain.
						load = 1'b1;
						if (remain > $signed({8'b0, table_last_q})) begin
							rd_idx = table_last_q;
						end else if (remain < 0) begin
							rd_idx = '0;
						end else begin
							rd_idx = remain[IndexWidth-1:0];
						end
					end
				end
			end
			OP_PULSE: begin
				if (running_q) begin
					if (step_next >= move_length_q) begin
						done      = 1'b1;
						running_n = 1'b0;
						step_n    = '0;
					end else begin
						step_n = step_next[StepWidth-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	generate
		if (DirectIndex) begin : g_direct
			assign mem_raddr = AW'(rd_idx);
			assign mem_waddr = AW'(table_index);
		end else begin : g_wrap
			assign mem_raddr = AW'(wrap_index(rd_idx, TABLE_DEPTH));
			assign mem_waddr = AW'(wrap_index(table_index, TABLE_DEPTH));
		end
	endgenerate

	assign mem_wdata = PERIOD_WIDTH'(table_value);
	assign mem_re    = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			tick_q    <= '0;
			running_q <= 1'b0;
			accel_q   <= RampReset;
			decel_q   <= RampReset;
		end else if (accept) begin
			step_q    <= step_n;
			tick_q    <= tick_n;
			running_q <= running_n;
			accel_q   <= accel_n;
			decel_q   <= decel_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.load   <= load;
			s1_q.moving <= running_n;
			s1_q.done   <= done;
			s1_q.steps  <= step_n;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1       = s1_q;

endmodule

// File: sv/spcg_out.sv
// ----------------------------------------------------------------------------
// spcg_out
// Period register and output register of the result channel.
// ----------------------------------------------------------------------------
module spcg_out
	import spcg_pkg::*;
#(
	parameter int PERIOD_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s1_valid,
	input  s1_t                     s1,
	input  logic [PERIOD_WIDTH-1:0] rdata,
	input  logic                    out_ready,
	output logic                    advance,
	output logic                    out_valid,
	output logic [OutWidth-1:0]     pulse_period,
	output logic [OutWidth-2:0]     pulse_compare,
	output logic                    moving,
	output logic                    move_done,
	output logic [StepWidth-1:0]    steps_done
);

	logic [PERIOD_WIDTH-1:0] period_q;
	logic [PERIOD_WIDTH-1:0] period_n;
	logic [OutWidth-1:0]     period_out;
	logic                    out_valid_q;
	logic                    moving_q;
	logic                    done_q;
	logic [StepWidth-1:0]    steps_q;

	assign advance  = !out_valid_q || out_ready;
	assign period_n = s1.load ? rdata : period_q;

	// The period register doubles as the result field and keeps its value
	// after the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_WIDTH'(PeriodReset);
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
			if (s1_valid) begin
				period_q <= period_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid) begin
			moving_q <= s1.moving;
			done_q   <= s1.done;
			steps_q  <= s1.steps;
		end
	end

	assign period_out    = OutWidth'(period_q);
	assign out_valid     = out_valid_q;
	assign pulse_period  = period_out;
	assign pulse_compare = period_out[OutWidth-1:1];
	assign moving        = moving_q;
	assign move_done     = done_q;
	assign steps_done    = steps_q;

endmodule

// File: sv/stepper_s_curve_profile_generator_unit.sv
// ----------------------------------------------------------------------------
// Stepper S-curve profile generator
// Produces the step-pulse period and compare value for a stepper move from a
// loaded profile table, tracking ramp phases and completed step pulses.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser op, tdata table_index, table_value
// m_*      out  m_tvalid/m_tready  tdata period, compare, moving, done, steps
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One item is accepted per cycle while s_tready is high; each gives one result.
// The table read issued at acceptance is registered with the control stage.
// Reset clears the move state and sets the period to 2000; the table holds
// no defined value until written. A stalled result holds the control
// stage, and the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module stepper_s_curve_profile_generator_unit
	import spcg_pkg::*;
#(
	parameter int TABLE_DEPTH  = TableDepthDefault,
	parameter int PERIOD_WIDTH = PeriodWidthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CfgWidth-1:0] cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          s_tuser,  // [1:0] op
	input  logic [31:0]         s_tdata,  // [9:0] table_index, [25:10] table_value
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [55:0]         m_tdata   // [15:0] pulse_period, [30:16] pulse_compare,
	                                      // [31] moving, [32] move_done, [48:33] steps_done
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic                    accept;
	logic                    advance;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [PERIOD_WIDTH-1:0] mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;
	logic [PERIOD_WIDTH-1:0] mem_rdata;
	logic                    s1_valid;
	s1_t                     s1;
	logic [OutWidth-1:0]     pulse_period;
	logic [OutWidth-2:0]     pulse_compare;
	logic                    moving;
	logic                    move_done;
	logic [StepWidth-1:0]    steps_done;

	assign s_tready = !s1_valid || advance;
	assign accept   = s_tvalid && s_tready;

	spcg_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PERIOD_WIDTH(PERIOD_WIDTH),
		.AW          (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.advance    (advance),
		.op         (s_tuser),
		.table_index(s_tdata[9:0]),
		.table_value(s_tdata[25:10]),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.s1_valid   (s1_valid),
		.s1         (s1)
	);

	spcg_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PERIOD_WIDTH(PERIOD_WIDTH),
		.AW          (AW)
	) u_table (
		.clk  (clk),
		.we   (mem_we && accept),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	spcg_out #(
		.PERIOD_WIDTH(PERIOD_WIDTH)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.s1           (s1),
		.rdata        (mem_rdata),
		.out_ready    (m_tready),
		.advance      (advance),
		.out_valid    (m_tvalid),
		.pulse_period (pulse_period),
		.pulse_compare(pulse_compare),
		.moving       (moving),
		.move_done    (move_done),
		.steps_done   (steps_done)
	);

	assign m_tdata = {7'd0, steps_done, move_done, moving, pulse_compare, pulse_period};

`include "stepper_s_curve_profile_generator_unit_assert.svh"

	`SPCG_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
	`SPCG_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid, "accepted item lost in control stage")
	`SPCG_ASSERT_SAME(a_done_stops, m_tvalid && move_done, !moving, "move ended but still moving")
	`SPCG_ASSERT_SAME(a_idle_steps_zero, m_tvalid && !moving, steps_done == '0,
		"step count not cleared while idle")

endmodule

// File: tb/profile_checker.sv
// ----------------------------------------------------------------------------
// Profile generator checker
// Watches the configuration port and both streams of the S-curve profile
// generator, keeps its own copy of the table, move state and registers,
// predicts the result of every accepted item and compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module profile_checker
	import spcg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CfgWidth-1:0] cfg_data,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [1:0]          s_tuser,   // [1:0] op
	input  logic [31:0]         s_tdata,   // [9:0] table_index, [25:10] table_value
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [55:0]         m_tdata,   // [15:0] pulse_period, [30:16] pulse_compare,
	                                       // [31] moving, [32] move_done, [48:33] steps_done
	output int                  mismatches,
	output int                  outstanding
);

	// Laid out as the low 49 bits of m_tdata.
	typedef struct packed {
		logic [15:0] steps;
		logic        done;
		logic        moving;
		logic [14:0] compare;
		logic [15:0] period;
	} motion_t;

	motion_t     expected_motion[$];
	motion_t     seen_motion;
	motion_t     want_motion;
	logic [15:0] period_table [1024];
	int          fail_count = 0;

	int unsigned step_cnt;
	int unsigned tick_idx;
	int unsigned period_now;
	int unsigned accel_len;
	int unsigned decel_len;
	bit          busy;

	int unsigned move_len;
	int unsigned accel_req;
	int unsigned decel_req;
	int unsigned last_idx;

	assign mismatches = fail_count;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// Applies one item to the move state and returns the result it gives.
	function automatic motion_t next_motion(op_t op, logic [9:0] idx, logic [15:0] val);
		motion_t     r;
		int unsigned nxt;
		longint      remain;
		bit          fin;
		fin = 1'b0;
		case (op)
			OP_TABLE_WRITE: period_table[idx] = val;
			OP_START: begin
				if (move_len < accel_req + decel_req) begin
					accel_len = (move_len / 2) & 16'hFFFF;
					decel_len = accel_len;
				end else begin
					accel_len = accel_req;
					decel_len = decel_req;
				end
				step_cnt   = 0;
				tick_idx   = 0;
				period_now = 32'(period_table[0]);
				busy       = 1'b1;
			end
			OP_TICK: begin
				if (busy) begin
					if (step_cnt <= accel_len) begin
						// Walking up the table; the index parks one past the last entry.
						if (tick_idx <= last_idx) begin
							period_now = 32'(period_table[tick_idx]);
							tick_idx   = (tick_idx + 1) & 11'h7FF;
						end
					end else if (longint'(step_cnt) >
							longint'(move_len) - longint'(decel_len)) begin
						remain = longint'(move_len) - longint'(step_cnt);
						if (remain > longint'(last_idx)) remain = longint'(last_idx);
						if (remain < 0) remain = 0;
						period_now = 32'(period_table[int'(remain)]);
					end
				end
			end
			OP_PULSE: begin
				if (busy) begin
					nxt = step_cnt + 1;
					if (nxt >= move_len) begin
						fin      = 1'b1;
						busy     = 1'b0;
						step_cnt = 0;
					end else begin
						step_cnt = nxt & 16'hFFFF;
					end
				end
			end
		endcase
		r.period  = period_now[15:0];
		r.compare = period_now[15:1];
		r.moving  = busy;
		r.done    = fin;
		r.steps   = step_cnt[15:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt   = 0;
			tick_idx   = 0;
			period_now = PeriodReset;
			accel_len  = 32'(RampReset);
			decel_len  = 32'(RampReset);
			busy       = 1'b0;
			move_len   = 32'(MoveLengthReset);
			accel_req  = 32'(RampReset);
			decel_req  = 32'(RampReset);
			last_idx   = 32'(TableLastReset);
			expected_motion.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MOVE_LENGTH:   move_len  = 32'(cfg_data);
					CFG_ACCEL_REQUEST: accel_req = 32'(cfg_data[15:0]);
					CFG_DECEL_REQUEST: decel_req = 32'(cfg_data[15:0]);
					CFG_TABLE_LAST:    last_idx  = 32'(cfg_data[9:0]);
				endcase
			end
			if (s_tvalid && s_tready)
				expected_motion.push_back(next_motion(op_t'(s_tuser), s_tdata[9:0],
					s_tdata[25:10]));
			if (m_tvalid && m_tready) begin
				seen_motion = m_tdata[48:0];
				if (expected_motion.size() == 0) begin
					report_mismatch("result with nothing expected, period", seen_motion.period, 0);
				end else begin
					want_motion = expected_motion.pop_front();
					if (seen_motion.period !== want_motion.period)
						report_mismatch("pulse_period", seen_motion.period, want_motion.period);
					if (seen_motion.compare !== want_motion.compare)
						report_mismatch("pulse_compare", seen_motion.compare, want_motion.compare);
					if (seen_motion.moving !== want_motion.moving)
						report_mismatch("moving", seen_motion.moving, want_motion.moving);
					if (seen_motion.done !== want_motion.done)
						report_mismatch("move_done", seen_motion.done, want_motion.done);
					if (seen_motion.steps !== want_motion.steps)
						report_mismatch("steps_done", seen_motion.steps, want_motion.steps);
				end
			end
			outstanding <= expected_motion.size();
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Stepper S-curve profile generator testbench
// Loads the profile table, runs a short directed sequence through idle
// events, the ramp phases, restart and move end, then random moves under
// many register settings with random gaps on the input and random stalls
// on the output. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
	import spcg_pkg::*;

	localparam int StallLimit = 4000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [1:0]          cfg_index = CFG_MOVE_LENGTH;
	logic [CfgWidth-1:0] cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [1:0]          s_tuser   = OP_TABLE_WRITE;
	logic [31:0]         s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [55:0]         m_tdata;

	int mismatches;
	int outstanding;
	bit calm = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	stepper_s_curve_profile_generator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	profile_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// The valid stays high between back-to-back items and drops only for a gap.
	task automatic send_item(op_t op, logic [9:0] idx, logic [15:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, val, idx};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_event(op_t op);
		send_item(op, 10'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_config(int unsigned len, int unsigned acc, int unsigned dec,
			int unsigned last);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MOVE_LENGTH;
		cfg_data  <= CfgWidth'(len);
		@(posedge clk);
		cfg_index <= CFG_ACCEL_REQUEST;
		cfg_data  <= CfgWidth'(acc);
		@(posedge clk);
		cfg_index <= CFG_DECEL_REQUEST;
		cfg_data  <= CfgWidth'(dec);
		@(posedge clk);
		cfg_index <= CFG_TABLE_LAST;
		cfg_data  <= CfgWidth'(last);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: mostly ready, with short stalls and now and then a long one.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			m_tready  <= 1'b0;
			hold_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
				: $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= StallLimit) begin
				$display("stepper_s_curve_profile_generator_unit: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned len;
		int unsigned acc;
		int unsigned dec;
		int unsigned last;
		int unsigned n;
		int unsigned r;
		int unsigned random_items;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry is written before any move, so no read hits an empty entry.
		for (int i = 0; i < 1024; i++)
			send_item(OP_TABLE_WRITE, 10'(i),
				(i < 800) ? 16'(1990 - (i * 1480) / 799) : 16'($urandom));

		// Short move: idle events, acceleration up to saturation, cruise,
		// deceleration, a restart in mid-move and the end of the move.
		drain();
		set_config(6, 2, 2, 3);
		send_event(OP_TICK);
		send_event(OP_PULSE);
		send_item(OP_TABLE_WRITE, 10'd0, 16'hFFFF);
		send_item(OP_TABLE_WRITE, 10'h3FF, 16'h0000);
		send_event(OP_START);
		repeat (5) send_event(OP_TICK);
		repeat (3) send_event(OP_PULSE);
		send_event(OP_TICK);
		repeat (2) send_event(OP_PULSE);
		send_event(OP_TICK);
		send_event(OP_START);
		repeat (6) send_event(OP_PULSE);

		// Zero-length move with oversized ramps: ramps halve to zero and the
		// first pulse ends the move.
		drain();
		set_config(0, 65535, 65535, 1023);
		send_event(OP_START);
		send_event(OP_TICK);
		send_event(OP_PULSE);

		random_items = 0;
		while (random_items < 450) begin
			drain();
			r = $urandom_range(0, 19);
			if (r < 2) len = 65536;
			else if (r < 3) len = 1;
			else if (r < 5) len = $urandom_range(0, 65536);
			else len = $urandom_range(2, 60);
			r = $urandom_range(0, 9);
			acc = (r == 0) ? 0 : (r == 1) ? 65535 : (r < 4) ? $urandom_range(0, 65535)
				: $urandom_range(0, 40);
			r = $urandom_range(0, 9);
			dec = (r == 0) ? 0 : (r == 1) ? 65535 : (r < 4) ? $urandom_range(0, 65535)
				: $urandom_range(0, 40);
			r = $urandom_range(0, 9);
			last = (r == 0) ? 0 : (r == 1) ? 1023 : (r < 4) ? $urandom_range(0, 1023)
				: $urandom_range(0, 40);
			set_config(len, acc, dec, last);
			calm <= ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) != 0) send_event(OP_START);
			n = $urandom_range(40, 120);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 4) send_event(OP_START);
				else if (r < 9) send_item(OP_TABLE_WRITE, 10'($urandom), 16'($urandom));
				else if (r < 55) send_event(OP_TICK);
				else send_event(OP_PULSE);
			end
			random_items += n + 1;
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("stepper_s_curve_profile_generator_unit: match");
		else
			$display("stepper_s_curve_profile_generator_unit: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/spcg_pkg.sv
sv/spcg_table.sv
sv/spcg_ctrl.sv
sv/spcg_out.sv
sv/stepper_s_curve_profile_generator_unit.sv
tb/profile_checker.sv
tb/testbench.sv
